@@ rtl/core/odqkc_pkg.sv @@
// ----------------------------------------------------------------------------
// odqkc_pkg: shared types and codes for the ordered deque
// Beat payloads, command and status codes, and the control word that the
// top level hands to every cell of the chain.
// ----------------------------------------------------------------------------
package odqkc_pkg;

  localparam logic [2:0] FUNC_APPEND      = 3'd0;
  localparam logic [2:0] FUNC_INSERT      = 3'd1;
  localparam logic [2:0] FUNC_CANCEL_KEY  = 3'd2;
  localparam logic [2:0] FUNC_CANCEL_HEAD = 3'd3;
  localparam logic [2:0] FUNC_LOOKUP      = 3'd4;
  localparam logic [2:0] FUNC_NEXT_AFTER  = 3'd5;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] ticket_key;
    logic [15:0] customer_tag;
    logic [15:0] ride_tag;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] entry_key;
    logic [15:0] entry_customer;
    logic [15:0] entry_ride;
    logic [4:0]  occupancy;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] customer;
    logic [15:0] ride;
  } tags_t;

  typedef struct packed {
    logic search;     // latch the key compare in every cell
    logic head_mode;  // match on the head cell instead of the key
    logic do_append;  // load the command into the cell just past the tail
    logic do_insert;  // shift every cell one place back, load the head
    logic do_remove;  // close the gap at the first match
    logic rep_found;  // report the first matching cell
    logic rep_next;   // report the cell after the first match
  } cell_ctl_t;

endpackage

@@ rtl/core/odqkc_cell.sv @@
// ----------------------------------------------------------------------------
// odqkc_cell: one position of the ordered list
// Holds one entry, compares its key with the command and hands its entry
// and the first-match flag on to its neighbours.
// ----------------------------------------------------------------------------
module odqkc_cell #(
  parameter int KEY_WIDTH = 16,
  parameter int CW        = 5,
  parameter int IDX       = 0
) (
  input  logic                      clk,
  input  odqkc_pkg::cell_ctl_t      ctl,
  input  logic [KEY_WIDTH-1:0]      cmd_key,
  input  odqkc_pkg::tags_t          cmd_tags,
  input  logic [CW-1:0]             count,
  input  logic [KEY_WIDTH-1:0]      left_key,
  input  odqkc_pkg::tags_t          left_tags,
  input  logic [KEY_WIDTH-1:0]      right_key,
  input  odqkc_pkg::tags_t          right_tags,
  input  logic                      before_in,
  output logic                      before_out,
  input  logic                      prev_hit_in,
  output logic                      hit_out,
  input  logic                      tail_in,
  output logic                      tail_out,
  input  logic [KEY_WIDTH-1:0]      rep_key_in,
  input  odqkc_pkg::tags_t          rep_tags_in,
  output logic [KEY_WIDTH-1:0]      rep_key_out,
  output odqkc_pkg::tags_t          rep_tags_out,
  output logic [KEY_WIDTH-1:0]      key_out,
  output odqkc_pkg::tags_t          tags_out
);

  logic [KEY_WIDTH-1:0] key_r;
  odqkc_pkg::tags_t     tags_r;
  logic                 match_r;
  logic                 live;
  logic                 hit;
  logic                 sel;

  assign live       = count > CW'(IDX);
  assign hit        = match_r & ~before_in;
  assign before_out = before_in | match_r;
  assign hit_out    = hit;
  assign tail_out   = tail_in | (hit & (count == CW'(IDX + 1)));

  assign sel = (ctl.rep_found & hit) | (ctl.rep_next & prev_hit_in & live);
  assign rep_key_out  = rep_key_in | (sel ? key_r : '0);
  assign rep_tags_out = rep_tags_in | (sel ? tags_r : '0);

  assign key_out  = key_r;
  assign tags_out = tags_r;

  always_ff @(posedge clk) begin
    if (ctl.search) begin
      match_r <= live && (ctl.head_mode ? (IDX == 0) : (key_r == cmd_key));
    end
    if (ctl.do_insert) begin
      key_r  <= (IDX == 0) ? cmd_key : left_key;
      tags_r <= (IDX == 0) ? cmd_tags : left_tags;
    end else if (ctl.do_append && (count == CW'(IDX))) begin
      key_r  <= cmd_key;
      tags_r <= cmd_tags;
    end else if (ctl.do_remove && before_out) begin
      // This cell sits at or behind the removed entry: pull from the right.
      key_r  <= right_key;
      tags_r <= right_tags;
    end
  end

endmodule

@@ rtl/core/ordered_deque_with_key_cancel.sv @@
// ----------------------------------------------------------------------------
// ordered_deque_with_key_cancel: bounded ordered list with delete by key
// Steps: accept registers the command, the search state latches the key
//   compare in every cell and commit registers the result, held off while
//   out_stall holds the last one; the next command waits until after commit.
// Reset: rst_n (synchronous, active low) empties the list and the output;
//   the cell contents are left as they are and never read before written.
// ----------------------------------------------------------------------------
module ordered_deque_with_key_cancel #(
  parameter int LIST_DEPTH = 16,
  parameter int KEY_WIDTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  odqkc_pkg::in_beat_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output odqkc_pkg::out_beat_t  out_data
);

  // The count has to hold LIST_DEPTH itself, so it is one bit wider than an
  // index would need when the depth is a power of two.
  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SRCH, ST_EXEC} state_t;

  state_t               state_r;
  odqkc_pkg::in_beat_t  cmd_r;
  odqkc_pkg::out_beat_t out_data_r;
  logic                 out_valid_r;
  logic [CW-1:0]        count_r;

  logic [KEY_WIDTH-1:0] cmd_key;
  odqkc_pkg::tags_t     cmd_tags;
  odqkc_pkg::cell_ctl_t ctl;
  logic                 commit;
  logic                 full;
  logic                 found;
  logic [1:0]           status;
  logic [CW-1:0]        count_nxt;

  // Chain wires: cell i reads element i and drives i+1; hit, key, tags: i.
  logic                 before_w [0:LIST_DEPTH];
  logic                 tail_w   [0:LIST_DEPTH];
  logic [KEY_WIDTH-1:0] rkey_w   [0:LIST_DEPTH];
  odqkc_pkg::tags_t     rtags_w  [0:LIST_DEPTH];
  logic                 hit_w    [0:LIST_DEPTH-1];
  logic [KEY_WIDTH-1:0] key_w    [0:LIST_DEPTH-1];
  odqkc_pkg::tags_t     tags_w   [0:LIST_DEPTH-1];

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Keys keep only their low KEY_WIDTH bits inside the list.
  assign cmd_key       = KEY_WIDTH'(cmd_r.ticket_key);
  assign cmd_tags.customer = cmd_r.customer_tag;
  assign cmd_tags.ride     = cmd_r.ride_tag;

  assign full   = (count_r == CW'(LIST_DEPTH));
  assign found  = before_w[LIST_DEPTH];
  // A finished result may only go out once the previous one has been taken.
  assign commit = (state_r == ST_EXEC) && !(out_valid_r && out_stall);

  always_comb begin
    ctl.search    = (state_r == ST_SRCH);
    ctl.head_mode = (cmd_r.func == odqkc_pkg::FUNC_CANCEL_HEAD);
    ctl.do_append = commit && !full && (cmd_r.func == odqkc_pkg::FUNC_APPEND);
    ctl.do_insert = commit && !full && (cmd_r.func == odqkc_pkg::FUNC_INSERT);
    ctl.do_remove = commit && found &&
                    ((cmd_r.func == odqkc_pkg::FUNC_CANCEL_KEY) ||
                     (cmd_r.func == odqkc_pkg::FUNC_CANCEL_HEAD));
    ctl.rep_found = (cmd_r.func == odqkc_pkg::FUNC_CANCEL_KEY) ||
                    (cmd_r.func == odqkc_pkg::FUNC_CANCEL_HEAD) ||
                    (cmd_r.func == odqkc_pkg::FUNC_LOOKUP);
    ctl.rep_next  = (cmd_r.func == odqkc_pkg::FUNC_NEXT_AFTER);
  end

  // Status and the count after the command. A match can only arise inside
  // the held part of the list, so no match on an empty list is guaranteed.
  always_comb begin
    status    = odqkc_pkg::STATUS_DONE;
    count_nxt = count_r;
    case (cmd_r.func)
      odqkc_pkg::FUNC_APPEND, odqkc_pkg::FUNC_INSERT: begin
        if (full) begin
          status = odqkc_pkg::STATUS_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      odqkc_pkg::FUNC_CANCEL_KEY, odqkc_pkg::FUNC_CANCEL_HEAD: begin
        if (count_r == '0) begin
          status = odqkc_pkg::STATUS_EMPTY;
        end else if (!found) begin
          status = odqkc_pkg::STATUS_NOT_FOUND;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      odqkc_pkg::FUNC_LOOKUP, odqkc_pkg::FUNC_NEXT_AFTER: begin
        if (count_r == '0) begin
          status = odqkc_pkg::STATUS_EMPTY;
        end else if (!found) begin
          status = odqkc_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
        status = odqkc_pkg::STATUS_DONE;
      end
    endcase
  end

  assign before_w[0] = 1'b0;
  assign tail_w[0]   = 1'b0;
  assign rkey_w[0]   = '0;
  assign rtags_w[0]  = '0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key;
    odqkc_pkg::tags_t     left_tags;
    logic [KEY_WIDTH-1:0] right_key;
    odqkc_pkg::tags_t     right_tags;
    logic                 prev_hit;

    if (i == 0) begin : g_head
      // The head reports as the successor when the match sits at the tail.
      assign left_key  = '0;
      assign left_tags = '0;
      assign prev_hit  = tail_w[LIST_DEPTH];
    end else begin : g_body
      assign left_key  = key_w[i-1];
      assign left_tags = tags_w[i-1];
      assign prev_hit  = hit_w[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_key  = '0;
      assign right_tags = '0;
    end else begin : g_inner
      assign right_key  = key_w[i+1];
      assign right_tags = tags_w[i+1];
    end

    odqkc_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CW        (CW),
      .IDX       (i)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .cmd_key      (cmd_key),
      .cmd_tags     (cmd_tags),
      .count        (count_r),
      .left_key     (left_key),
      .left_tags    (left_tags),
      .right_key    (right_key),
      .right_tags   (right_tags),
      .before_in    (before_w[i]),
      .before_out   (before_w[i+1]),
      .prev_hit_in  (prev_hit),
      .hit_out      (hit_w[i]),
      .tail_in      (tail_w[i]),
      .tail_out     (tail_w[i+1]),
      .rep_key_in   (rkey_w[i]),
      .rep_tags_in  (rtags_w[i]),
      .rep_key_out  (rkey_w[i+1]),
      .rep_tags_out (rtags_w[i+1]),
      .key_out      (key_w[i]),
      .tags_out     (tags_w[i])
    );
  end

  // Command sequencing, the held count and the output register. The report
  // chain yields zero when no cell is selected, which covers every status
  // other than done as well as append and insert.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_data;
            state_r <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          if (commit) begin
            count_r                   <= count_nxt;
            out_data_r.status         <= status;
            out_data_r.entry_key      <= 16'(rkey_w[LIST_DEPTH]);
            out_data_r.entry_customer <= rtags_w[LIST_DEPTH].customer;
            out_data_r.entry_ride     <= rtags_w[LIST_DEPTH].ride;
            out_data_r.occupancy      <= 5'(count_nxt);
            state_r                   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      out_valid_r <= (out_valid_r && out_stall) || commit;
    end
  end

endmodule
